@@ design/wcdv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted check digit verifier package
// Shared sizes, register codes, configuration and control types, and the
// helper that splits a BCD word into digits.
// ----------------------------------------------------------------------------
package wcdv_pkg;

  localparam int unsigned DIGIT_COUNT = 10;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned WORD_W      = DIGIT_COUNT * DIGIT_W;
  localparam int unsigned IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned TERM_W      = 8;
  localparam int unsigned SUM_W       = $clog2(DIGIT_COUNT * 225 + 1);
  localparam int unsigned REG_IDX_W   = 3;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [DIGIT_COUNT-1:0] digit_vec_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRIMARY_WEIGHTS   = 3'd0,
    REG_ALTERNATE_WEIGHTS = 3'd1,
    REG_USE_MODULUS_11    = 3'd2,
    REG_PRIMARY_CROSS     = 3'd3,
    REG_ALTERNATE_CROSS   = 3'd4,
    REG_CHECK_POSITION    = 3'd5,
    REG_FALLBACK_MODE     = 3'd6,
    REG_SHIFT_COUNT       = 3'd7
  } wcdv_reg_e;

  typedef enum logic [1:0] {
    FB_NONE  = 2'd0,
    FB_ALT   = 2'd1,
    FB_SHIFT = 2'd2
  } wcdv_fb_e;

  localparam logic [POS_W-1:0] CHECK_POS_RESET = 4'd10;

  typedef struct packed {
    logic [WORD_W-1:0] pri_weights;
    logic [WORD_W-1:0] alt_weights;
    logic              mod11;
    logic              pri_cross;
    logic              alt_cross;
    logic [POS_W-1:0]  check_pos;
    logic [1:0]        fb_mode;
    logic [1:0]        shift_cnt;
  } wcdv_cfg_t;

  localparam wcdv_cfg_t CFG_RESET = '{
    pri_weights: '0,
    alt_weights: '0,
    mod11:       1'b0,
    pri_cross:   1'b0,
    alt_cross:   1'b0,
    check_pos:   CHECK_POS_RESET,
    fb_mode:     2'd0,
    shift_cnt:   2'd0
  };

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } wcdv_en_t;

  function automatic digit_vec_t unpack_digits(logic [WORD_W-1:0] word);
    digit_vec_t v;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      v[i] = word[DIGIT_W*(DIGIT_COUNT-1-i) +: DIGIT_W];
    end
    return v;
  endfunction

endpackage

@@ design/weighted_check_digit_verifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted check digit verifier
// Checks a BCD account number against a weighted mod 10 / mod 11 check
// digit, with an optional alternate-weight or shift-left retry.
// ----------------------------------------------------------------------------
// Accepts one account number per clock while no stall is held and returns one
// result per number through the term stage, sum stage, check digit stage and
// compare and output register. The primary and fallback passes run side by
// side in two copies of the pass pipeline, so the fallback adds no stage.
// Stalls propagate backward combinationally and only hold stages that carry
// a valid item. Configuration registers take effect on items in flight, so
// write them only while the block is empty.
// ----------------------------------------------------------------------------
module weighted_check_digit_verifier import wcdv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [WORD_W-1:0]    account_bcd_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic                 number_valid_o,
  output logic [DIGIT_W-1:0]   computed_digit_o,
  output logic                 fallback_matched_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  typedef struct packed {
    digit_t pri_ref;
    digit_t fb_ref;
    logic   fb_en;
  } side_t;

  wcdv_cfg_t         cfg;
  wcdv_en_t          en;
  logic              en_s1, en_s2, en_s3;
  logic              en_out;
  logic              v1_q, v2_q, v3_q, vo_q;
  side_t             side1_q, side2_q, side3_q, side_d;
  digit_vec_t        digits, fb_digits;
  logic [WORD_W-1:0] shifted_word;
  logic [WORD_W-1:0] fb_weights;
  logic              fb_cross;
  logic [POS_W:0]    pos;
  logic [IDX_W-1:0]  ci;
  logic [POS_W:0]    ci_full;
  digit_t            pri_check, fb_check;
  logic              ok, fb_ok;
  logic              number_valid_q, fallback_matched_q;
  digit_t            computed_digit_q;

  wcdv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign en_out  = !vo_q || !stall_i;
  assign en_s3   = !v3_q || en_out;
  assign en_s2   = !v2_q || en_s3;
  assign en_s1   = !v1_q || en_s2;
  assign en      = '{s1: en_s1, s2: en_s2, s3: en_s3};
  assign stall_o = !en_s1;

  assign digits       = unpack_digits(account_bcd_i);
  assign shifted_word = account_bcd_i << {cfg.shift_cnt, 2'b00};

  always_comb begin
    pos = {1'b0, cfg.check_pos};
    if (pos == '0) begin
      ci_full = '0;
    end else if (pos > (POS_W+1)'(DIGIT_COUNT)) begin
      ci_full = (POS_W+1)'(DIGIT_COUNT - 1);
    end else begin
      ci_full = pos - 1'b1;
    end
    ci = ci_full[IDX_W-1:0];
  end

  always_comb begin
    if (cfg.fb_mode == FB_SHIFT) begin
      fb_digits  = unpack_digits(shifted_word);
      fb_weights = cfg.pri_weights;
      fb_cross   = cfg.pri_cross;
    end else begin
      fb_digits  = digits;
      fb_weights = cfg.alt_weights;
      fb_cross   = cfg.alt_cross;
    end
    side_d.pri_ref = digits[ci];
    side_d.fb_ref  = fb_digits[ci];
    side_d.fb_en   = (cfg.fb_mode == FB_ALT) || (cfg.fb_mode == FB_SHIFT);
  end

  wcdv_pass u_pri_pass (
    .clk_i     (clk_i),
    .en_i      (en),
    .digits_i  (digits),
    .weights_i (cfg.pri_weights),
    .cross_i   (cfg.pri_cross),
    .mod11_i   (cfg.mod11),
    .check_o   (pri_check)
  );

  wcdv_pass u_fb_pass (
    .clk_i     (clk_i),
    .en_i      (en),
    .digits_i  (fb_digits),
    .weights_i (fb_weights),
    .cross_i   (fb_cross),
    .mod11_i   (cfg.mod11),
    .check_o   (fb_check)
  );

  assign ok    = (side3_q.pri_ref == pri_check);
  assign fb_ok = side3_q.fb_en && !ok && (side3_q.fb_ref == fb_check);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_s1) begin
        v1_q <= valid_i;
      end
      if (en_s2) begin
        v2_q <= v1_q;
      end
      if (en_s3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      side1_q <= side_d;
    end
    if (en_s2) begin
      side2_q <= side1_q;
    end
    if (en_s3) begin
      side3_q <= side2_q;
    end
    if (en_out) begin
      number_valid_q     <= ok || fb_ok;
      computed_digit_q   <= pri_check;
      fallback_matched_q <= fb_ok;
    end
  end

  assign valid_o            = vo_q;
  assign number_valid_o     = number_valid_q;
  assign computed_digit_o   = computed_digit_q;
  assign fallback_matched_o = fallback_matched_q;

endmodule

@@ design/wcdv_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the weight sets, modulus, crossfoot, check position and fallback
// settings; written one register per transfer.
// ----------------------------------------------------------------------------
module wcdv_cfg import wcdv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  output wcdv_cfg_t            cfg_o
);

  wcdv_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (wcdv_reg_e'(cfg_index_i))
        REG_PRIMARY_WEIGHTS:   cfg_d.pri_weights = cfg_data_i;
        REG_ALTERNATE_WEIGHTS: cfg_d.alt_weights = cfg_data_i;
        REG_USE_MODULUS_11:    cfg_d.mod11       = cfg_data_i[0];
        REG_PRIMARY_CROSS:     cfg_d.pri_cross   = cfg_data_i[0];
        REG_ALTERNATE_CROSS:   cfg_d.alt_cross   = cfg_data_i[0];
        REG_CHECK_POSITION:    cfg_d.check_pos   = cfg_data_i[POS_W-1:0];
        REG_FALLBACK_MODE:     cfg_d.fb_mode     = cfg_data_i[1:0];
        REG_SHIFT_COUNT:       cfg_d.shift_cnt   = cfg_data_i[1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/wcdv_pass.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Check digit pass
// Three register stages: weighted (optionally crossfooted) terms, their sum,
// and the check digit from the sum modulo 10 or 11.
// ----------------------------------------------------------------------------
module wcdv_pass import wcdv_pkg::*; (
  input  logic              clk_i,
  input  wcdv_en_t          en_i,
  input  digit_vec_t        digits_i,
  input  logic [WORD_W-1:0] weights_i,
  input  logic              cross_i,
  input  logic              mod11_i,
  output digit_t            check_o
);

  localparam int unsigned PROD_W = SUM_W + 13;
  localparam int unsigned QUOT_W = SUM_W - 3;

  function automatic logic [TERM_W-1:0] term_f(digit_t d, digit_t w, logic xfoot);
    logic [7:0]  p;
    logic [15:0] scaled;
    logic [4:0]  q;
    logic [7:0]  r;
    p      = {4'b0, d} * {4'b0, w};
    scaled = {8'b0, p} * 16'd205;
    q      = scaled[15:11];
    r      = p - ({3'b0, q} * 8'd10);
    return xfoot ? ({3'b0, q} + r) : p;
  endfunction

  function automatic digit_t digit_f(logic [SUM_W-1:0] sum, logic mod11);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] q;
    logic [SUM_W-1:0]  qm;
    logic [SUM_W-1:0]  rem;
    logic [4:0]        r;
    logic [3:0]        m;
    m    = mod11 ? 4'd11 : 4'd10;
    prod = PROD_W'(sum) * PROD_W'(mod11 ? 13'd5957 : 13'd6553);
    q    = prod[PROD_W-1:16];
    qm   = SUM_W'(q) * SUM_W'(m);
    rem  = sum - qm;
    r    = rem[4:0];
    if (r >= {1'b0, m}) begin
      r = r - {1'b0, m};
    end
    if (r == 5'd0) begin
      return 4'd0;
    end else if (mod11 && r == 5'd1) begin
      return 4'd0;
    end else begin
      return m - r[3:0];
    end
  endfunction

  digit_vec_t        weights;
  logic [TERM_W-1:0] term_q [DIGIT_COUNT];
  logic [TERM_W-1:0] term_d [DIGIT_COUNT];
  logic [SUM_W-1:0]  sum_q, sum_d;
  digit_t            check_q, check_d;

  assign weights = unpack_digits(weights_i);

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      term_d[i] = term_f(digits_i[i], weights[i], cross_i);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      sum_d = sum_d + SUM_W'(term_q[i]);
    end
  end

  assign check_d = digit_f(sum_q, mod11_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      term_q <= term_d;
    end
    if (en_i.s2) begin
      sum_q <= sum_d;
    end
    if (en_i.s3) begin
      check_q <= check_d;
    end
  end

  assign check_o = check_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted check digit verifier testbench
// Drives account numbers through the verifier under many register settings.
// A scoreboard predicts each verdict from its own copy of the registers, and
// the results are checked in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import wcdv_pkg::*; ();

  localparam int unsigned PIPE_LATENCY   = 4;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam logic [1:0]  FB_UNUSED      = 2'd3;

  typedef enum {PASS_PRIMARY, PASS_ALTERNATE, PASS_SHIFTED} pass_e;

  typedef struct {
    logic             number_valid;
    logic [DIGIT_W-1:0] computed_digit;
    logic             fallback_matched;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 valid_i = 1'b0;
  logic                 stall_o;
  logic [WORD_W-1:0]    account_bcd_i = '0;
  logic                 valid_o;
  logic                 stall_i = 1'b0;
  logic                 number_valid_o;
  logic [DIGIT_W-1:0]   computed_digit_o;
  logic                 fallback_matched_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0]    cfg_data_i = '0;

  bit          tx_gaps = 1'b0;
  bit          rx_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  bit          burst_stall = 1'b0;
  int unsigned quiet_cycles = 0;

  class account_checker;
    wcdv_cfg_t   cfg;
    verdict_t    pending_verdicts[$];
    int unsigned mismatches;

    function new();
      cfg = '0;
      cfg.check_pos = CHECK_POS_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(wcdv_reg_e idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_PRIMARY_WEIGHTS:   cfg.pri_weights = data;
        REG_ALTERNATE_WEIGHTS: cfg.alt_weights = data;
        REG_USE_MODULUS_11:    cfg.mod11 = data[0];
        REG_PRIMARY_CROSS:     cfg.pri_cross = data[0];
        REG_ALTERNATE_CROSS:   cfg.alt_cross = data[0];
        REG_CHECK_POSITION:    cfg.check_pos = data[POS_W-1:0];
        REG_FALLBACK_MODE:     cfg.fb_mode = data[1:0];
        REG_SHIFT_COUNT:       cfg.shift_cnt = data[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned check_index();
      if (cfg.check_pos == 0) return 0;
      if (cfg.check_pos > DIGIT_COUNT) return DIGIT_COUNT - 1;
      return cfg.check_pos - 1;
    endfunction

    function logic [DIGIT_W-1:0] digit_at(logic [WORD_W-1:0] word, int unsigned idx);
      return word[DIGIT_W*(DIGIT_COUNT-1-idx) +: DIGIT_W];
    endfunction

    function logic [WORD_W-1:0] pass_word(logic [WORD_W-1:0] word, pass_e kind);
      if (kind == PASS_SHIFTED) return word << (DIGIT_W * cfg.shift_cnt);
      return word;
    endfunction

    function logic [DIGIT_W-1:0] pass_digit(logic [WORD_W-1:0] word, pass_e kind);
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] wts;
      bit                xfoot;
      int unsigned       sum;
      int unsigned       p;
      int unsigned       m;
      int unsigned       r;
      w     = pass_word(word, kind);
      wts   = (kind == PASS_ALTERNATE) ? cfg.alt_weights : cfg.pri_weights;
      xfoot = (kind == PASS_ALTERNATE) ? cfg.alt_cross : cfg.pri_cross;
      sum   = 0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        p = 32'(digit_at(w, i)) * 32'(digit_at(wts, i));
        if (xfoot) begin
          p = p / 10 + p % 10;
        end
        sum += p;
      end
      m = cfg.mod11 ? 11 : 10;
      r = sum % m;
      if (r == 0) begin
        r = m;
      end
      return DIGIT_W'((m - r) % 10);
    endfunction

    function bit pass_ok(logic [WORD_W-1:0] word, pass_e kind);
      return digit_at(pass_word(word, kind), check_index()) == pass_digit(word, kind);
    endfunction

    function logic [WORD_W-1:0] fit(logic [WORD_W-1:0] word, pass_e kind);
      logic [WORD_W-1:0] w;
      int unsigned       idx;
      idx = check_index() + ((kind == PASS_SHIFTED) ? cfg.shift_cnt : 0);
      if (idx >= DIGIT_COUNT) return word;
      w = word;
      for (int d = 0; d < 10; d++) begin
        w[DIGIT_W*(DIGIT_COUNT-1-idx) +: DIGIT_W] = DIGIT_W'(d);
        if (pass_ok(w, kind)) return w;
      end
      return word;
    endfunction

    function logic [WORD_W-1:0] random_bcd();
      logic [WORD_W-1:0] w;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        w[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
      end
      return w;
    endfunction

    function logic [WORD_W-1:0] make_account();
      logic [WORD_W-1:0] w;
      logic [63:0]       raw;
      int unsigned       r;
      int unsigned       idx;
      r = $urandom_range(0, 99);
      w = random_bcd();
      if (r < 45) return fit(w, PASS_PRIMARY);
      if (r < 65) begin
        if (cfg.fb_mode == FB_ALT) return fit(w, PASS_ALTERNATE);
        if (cfg.fb_mode == FB_SHIFT) return fit(w, PASS_SHIFTED);
        return fit(w, PASS_PRIMARY);
      end
      if (r < 75) begin
        w = fit(w, PASS_PRIMARY);
        idx = $urandom_range(0, DIGIT_COUNT - 1);
        w[DIGIT_W*idx +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
        return w;
      end
      if (r < 92) return w;
      raw = {$urandom(), $urandom()};
      return raw[WORD_W-1:0];
    endfunction

    function void note_account(logic [WORD_W-1:0] word);
      verdict_t v;
      bit       ok;
      bit       fb;
      ok = pass_ok(word, PASS_PRIMARY);
      fb = 1'b0;
      if (!ok && cfg.fb_mode == FB_ALT) begin
        fb = pass_ok(word, PASS_ALTERNATE);
      end else if (!ok && cfg.fb_mode == FB_SHIFT) begin
        fb = pass_ok(word, PASS_SHIFTED);
      end
      v.number_valid     = ok | fb;
      v.computed_digit   = pass_digit(word, PASS_PRIMARY);
      v.fallback_matched = fb;
      pending_verdicts = {pending_verdicts, v};
    endfunction

    function void flag(string field, logic [DIGIT_W-1:0] exp, logic [DIGIT_W-1:0] act);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, exp, act);
      end
    endfunction

    function void check_verdict(logic nv, logic [DIGIT_W-1:0] cd, logic fm);
      verdict_t e;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result with no account pending", $realtime);
        end
        return;
      end
      e = pending_verdicts.pop_front();
      if (nv !== e.number_valid) begin
        flag("number_valid", DIGIT_W'(e.number_valid), DIGIT_W'(nv));
      end
      if (cd !== e.computed_digit) flag("computed_digit", e.computed_digit, cd);
      if (fm !== e.fallback_matched) begin
        flag("fallback_matched", DIGIT_W'(e.fallback_matched), DIGIT_W'(fm));
      end
    endfunction
  endclass

  account_checker board = new();

  weighted_check_digit_verifier DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (valid_i),
    .stall_o            (stall_o),
    .account_bcd_i      (account_bcd_i),
    .valid_o            (valid_o),
    .stall_i            (stall_i),
    .number_valid_o     (number_valid_o),
    .computed_digit_o   (computed_digit_o),
    .fallback_matched_o (fallback_matched_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] pick_weights();
    logic [WORD_W-1:0] w;
    logic [63:0]       raw;
    case ($urandom_range(0, 5))
      0: return 40'h2121212120;
      1: return 40'h1731731730;
      2: return 40'h4327654320;
      3: return 40'h7654320000;
      4: begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          w[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(0, 10));
        end
        return w;
      end
      default: begin
        raw = {$urandom(), $urandom()};
        return raw[WORD_W-1:0];
      end
    endcase
  endfunction

  function automatic wcdv_cfg_t setting_for(int unsigned ph);
    wcdv_cfg_t s;
    if (ph == 0) begin
      s.pri_weights = '1;
      s.alt_weights = '1;
      s.mod11       = 1'b1;
      s.pri_cross   = 1'b1;
      s.alt_cross   = 1'b1;
      s.check_pos   = '1;
      s.fb_mode     = FB_UNUSED;
      s.shift_cnt   = 2'd3;
    end else if (ph == 1) begin
      s = '0;
      s.fb_mode = FB_NONE;
    end else begin
      s.pri_weights = pick_weights();
      s.alt_weights = pick_weights();
      s.mod11       = 1'($urandom_range(0, 1));
      s.pri_cross   = 1'($urandom_range(0, 1));
      s.alt_cross   = 1'($urandom_range(0, 1));
      s.check_pos   = POS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 10));
      s.fb_mode     = ($urandom_range(0, 9) == 0) ? FB_UNUSED
                                                  : 2'($urandom_range(0, 2));
      s.shift_cnt   = 2'($urandom_range(0, 3));
    end
    return s;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      board.check_verdict(number_valid_o, computed_digit_o, fallback_matched_o);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      stall_i <= 1'b1;
    end else if (!rx_gaps) begin
      stall_i <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_stall = ($urandom_range(0, 2) == 0);
        burst_left = burst_stall ? gap_len() + 1 : $urandom_range(1, 8);
      end
      stall_i <= burst_stall;
      burst_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_account(logic [WORD_W-1:0] word);
    valid_i <= 1'b1;
    account_bcd_i <= word;
    do @(posedge clk_i); while (stall_o);
    board.note_account(word);
  endtask

  task automatic run_phase(int unsigned count);
    int unsigned g;
    for (int unsigned i = 0; i < count; i++) begin
      g = tx_gaps ? gap_len() : 0;
      if (g != 0) begin
        valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      send_account(board.make_account());
    end
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_verdicts.size() != 0);
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic put_reg(wcdv_reg_e idx, logic [WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic load_setting(wcdv_cfg_t s);
    logic [63:0] n;
    drain_results();
    n = {$urandom(), $urandom()};
    put_reg(REG_PRIMARY_WEIGHTS, s.pri_weights);
    put_reg(REG_ALTERNATE_WEIGHTS, s.alt_weights);
    put_reg(REG_USE_MODULUS_11, {n[WORD_W-1:1], s.mod11});
    put_reg(REG_PRIMARY_CROSS, {n[WORD_W-2:0], s.pri_cross});
    put_reg(REG_ALTERNATE_CROSS, {n[WORD_W-1:1], s.alt_cross});
    put_reg(REG_CHECK_POSITION, {n[WORD_W-1:POS_W], s.check_pos});
    put_reg(REG_FALLBACK_MODE, {n[WORD_W-3:0], s.fb_mode});
    put_reg(REG_SHIFT_COUNT, {n[WORD_W-1:2], s.shift_cnt});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    wcdv_cfg_t s;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all weights zero, check digit in the last position
    rx_gaps = 1'b1;
    send_account(40'h0000000000);
    send_account(40'hFFFFFFFFFF);
    send_account(40'h9999999999);
    send_account(40'h1234567890);
    send_account(40'h1234567891);

    s = '0;
    s.pri_weights = 40'h2121212120;
    s.pri_cross   = 1'b1;
    s.check_pos   = 4'd10;
    s.fb_mode     = FB_NONE;
    load_setting(s);
    send_account(board.fit(40'h1234567890, PASS_PRIMARY));
    send_account(40'h9999999999);
    send_account(40'h0000000000);
    send_account(board.fit(40'h5550001110, PASS_PRIMARY) ^ 40'h1);

    // modulus eleven with alternate weights, remainder of zero included
    s.pri_weights = 40'h4327654320;
    s.alt_weights = 40'h1731731730;
    s.mod11       = 1'b1;
    s.pri_cross   = 1'b0;
    s.alt_cross   = 1'b1;
    s.fb_mode     = FB_ALT;
    load_setting(s);
    send_account(board.fit(40'h8765432100, PASS_PRIMARY));
    send_account(board.fit(40'h3141592650, PASS_ALTERNATE));
    send_account(board.random_bcd());
    send_account(40'h9090909090);

    // shift retry at full shift, check position zero taken as the first
    s.pri_weights = 40'h7654320000;
    s.fb_mode     = FB_SHIFT;
    s.shift_cnt   = 2'd3;
    s.check_pos   = 4'd0;
    load_setting(s);
    send_account(board.fit(40'h2718281828, PASS_SHIFTED));
    send_account(board.fit(40'h1111111111, PASS_PRIMARY));
    send_account(board.random_bcd());

    // non-decimal weights and digits, position past the end, unused mode
    s.pri_weights = '1;
    s.pri_cross   = 1'b1;
    s.check_pos   = 4'd15;
    s.fb_mode     = FB_UNUSED;
    s.shift_cnt   = 2'd0;
    load_setting(s);
    send_account(40'hFFFFFFFFFF);
    send_account(board.fit(40'h4444444444, PASS_PRIMARY));
    send_account(40'hABCDEF0123);

    // shift of zero repeats the primary check
    s.pri_weights = 40'h2121212120;
    s.fb_mode     = FB_SHIFT;
    s.check_pos   = 4'd5;
    load_setting(s);
    send_account(board.fit(40'h6020406080, PASS_SHIFTED));
    send_account(board.random_bcd());

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_setting(setting_for(ph));
      tx_gaps = (ph % 3 != 0);
      rx_gaps = (ph % 3 != 0);
      if (ph == 4) begin
        tx_gaps = 1'b0;
        hold_req = 1'b1;
      end
      if (ph == 7) begin
        run_phase(PHASE_ITEMS / 2);
        drain_results();
        run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_phase(PHASE_ITEMS);
      end
    end

    drain_results();
    if (board.pending_verdicts.size() != 0) begin
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
